[src/sle_pkg.sv]
// sle_pkg: shared types and constants of the sequential list engine
// operation codes, status codes, result record and default sizes
// no dependencies

package sle_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int CAP_W  = 7;
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]  found_position;
        logic [CNT_W-1:0]  element_count;
        logic              is_empty;
        logic              is_full;
    } t_result;

endpackage

[src/sle_mem.sv]
// sle_mem: element store, one write port and one read port
// read data registered; contents undefined until written
// no dependencies

module sle_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sle_ctrl.sv]
// sle_ctrl: operation sequencer of the list engine
// walks the element store one entry a cycle for shifts and searches
// depends on sle_pkg; drives sle_mem

module sle_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sle_pkg::CAP_W-1:0]   i_cap,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sle_pkg::OP_W-1:0]    i_op,
    input  logic [sle_pkg::POS_W-1:0]   i_pos,
    input  logic [sle_pkg::VAL_W-1:0]   i_val,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sle_pkg::t_result            o_res,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [7:0]                  o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [7:0]                  i_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WRVAL,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_valid, n_valid;
    sle_pkg::t_result            r_res, n_res;
    sle_pkg::t_op                r_op, n_op;
    logic [XW-1:0]               r_pos, n_pos;
    logic [sle_pkg::VAL_W-1:0]   r_val, n_val;
    logic [XW-1:0]               r_idx, n_idx;
    logic [XW-1:0]               r_lim, n_lim;
    logic                        r_pv, n_pv;
    logic [AW-1:0]               r_pa, n_pa;
    logic                        r_hit, n_hit;
    logic [sle_pkg::STAT_W-1:0]  r_status, n_status;
    logic [sle_pkg::VAL_W-1:0]   r_rd, n_rd;
    logic [sle_pkg::POS_W-1:0]   r_found, n_found;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] cap_eff;
    logic          issue;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        cnt_x = XW'(r_cnt);
        pos_x = XW'(i_pos);
        cap_x = XW'(i_cap);
        if (cap_x == '0) begin
            cap_eff = XW'(1);
        end else if (cap_x > XW'(DEPTH)) begin
            cap_eff = XW'(DEPTH);
        end else begin
            cap_eff = cap_x;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_valid  = r_valid && !i_ready;
        n_res    = r_res;
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_idx    = r_idx;
        n_lim    = r_lim;
        n_pv     = 1'b0;
        n_pa     = r_pa;
        n_hit    = r_hit;
        n_status = r_status;
        n_rd     = r_rd;
        n_found  = r_found;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = '0;
        o_re     = 1'b0;
        o_raddr  = '0;
        issue    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = sle_pkg::t_op'(i_op);
                    n_pos    = pos_x;
                    n_val    = i_val;
                    n_status = sle_pkg::ST_OK;
                    n_rd     = '0;
                    n_found  = '0;
                    n_hit    = 1'b0;
                    n_state  = S_WALK;
                    case (sle_pkg::t_op'(i_op))
                        sle_pkg::OP_INSERT: begin
                            n_idx = cnt_x;
                            if (pos_x == '0 || pos_x > cnt_x + XW'(1) || cnt_x >= cap_eff) begin
                                n_status = sle_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end
                        end
                        sle_pkg::OP_DELETE: begin
                            n_idx = pos_x - XW'(1);
                            n_lim = cnt_x;
                            if (cnt_x == '0 || pos_x == '0 || pos_x > cnt_x) begin
                                n_status = sle_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end
                        end
                        sle_pkg::OP_GET: begin
                            n_idx = pos_x - XW'(1);
                            n_lim = pos_x;
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = sle_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end
                        end
                        sle_pkg::OP_LOCATE: begin
                            n_idx    = '0;
                            n_lim    = cnt_x;
                            n_status = sle_pkg::ST_NOTFOUND;
                            if (cnt_x == '0) begin
                                n_state = S_DONE;
                            end
                        end
                        sle_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_status = sle_pkg::ST_BAD;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // issue the next read of the walk
                if (r_op == sle_pkg::OP_INSERT) begin
                    issue   = (r_idx >= r_pos);
                    o_raddr = AW'(r_idx - XW'(1));
                    n_idx   = r_idx - XW'(1);
                end else begin
                    issue   = (r_idx < r_lim) && !r_hit;
                    o_raddr = AW'(r_idx);
                    n_idx   = r_idx + XW'(1);
                end
                o_re = issue;
                n_pv = issue;
                n_pa = o_raddr;
                if (!issue) begin
                    n_idx = r_idx;
                end

                // consume the data of the previous read
                if (r_pv) begin
                    case (r_op)
                        sle_pkg::OP_INSERT: begin
                            o_we    = 1'b1;
                            o_waddr = r_pa + AW'(1);
                            o_wdata = i_rdata;
                        end
                        sle_pkg::OP_DELETE: begin
                            if (r_pa == AW'(r_pos - XW'(1))) begin
                                n_rd = i_rdata;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_pa - AW'(1);
                                o_wdata = i_rdata;
                            end
                        end
                        sle_pkg::OP_GET: begin
                            n_rd = i_rdata;
                        end
                        sle_pkg::OP_LOCATE: begin
                            if (!r_hit && i_rdata == r_val) begin
                                n_hit    = 1'b1;
                                n_status = sle_pkg::ST_OK;
                                n_found  = sle_pkg::POS_W'(XW'(r_pa) + XW'(1));
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (!issue) begin
                    if (r_op == sle_pkg::OP_INSERT) begin
                        n_state = S_WRVAL;
                    end else begin
                        if (r_op == sle_pkg::OP_DELETE) begin
                            n_cnt = r_cnt - CW'(1);
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_WRVAL: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_pos - XW'(1));
                o_wdata = r_val;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!n_valid) begin
                    n_valid              = 1'b1;
                    n_res.status         = r_status;
                    n_res.read_value     = r_rd;
                    n_res.found_position = r_found;
                    n_res.element_count  = sle_pkg::CNT_W'(cnt_x);
                    n_res.is_empty       = (r_cnt == '0);
                    n_res.is_full        = (cnt_x >= cap_eff);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_pv    <= n_pv;
        end
        r_res    <= n_res;
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_lim    <= n_lim;
        r_pa     <= n_pa;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_found  <= n_found;
    end

endmodule

[src/sequential_list_engine.sv]
// sequential_list_engine: ordered byte list with insert, delete, get, locate, clear
// one item in flight; insert, delete and locate walk the store one entry a cycle
// through its single read port and get reads one entry; result held in an output register
// reset: count 0, capacity 64, store contents undefined and never cleared
// depends on sle_pkg, sle_mem, sle_ctrl

module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,     // capacity
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // operation, position, value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // status, read_value, found_position,
                                         // element_count, is_empty, is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [sle_pkg::CAP_W-1:0] r_cap;
    sle_pkg::t_result          res;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [7:0]                wdata;
    logic                      re;
    logic [AW-1:0]             raddr;
    logic [7:0]                rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sle_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    sle_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tdata[2:0]),
        .i_pos   (i_s_axis_tdata[9:3]),
        .i_val   (i_s_axis_tdata[17:10]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    sle_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_m_axis_tdata = {6'd0, res.is_full, res.is_empty, res.element_count,
                             res.found_position, res.read_value, res.status};

endmodule

[verif/sequential_list_engine_test.sv]
// sequential_list_engine_test: self-checking bench for the sequential list engine
// drives list operations over the item stream, predicts each result and checks it
// depends on sle_pkg and sequential_list_engine

`timescale 1ns / 1ps

module sequential_list_engine_test;

    localparam int DEPTH  = sle_pkg::DEPTH_DEFAULT;
    localparam int SETTLE = DEPTH + 16;

    typedef struct packed {
        logic [sle_pkg::OP_W-1:0]  op;
        logic [sle_pkg::POS_W-1:0] pos;
        logic [sle_pkg::VAL_W-1:0] val;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // operation, position, value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // status, read_value, found_position,
                                        // element_count, is_empty, is_full

    sequential_list_engine #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // list shadow, updated on accepted items
    logic [sle_pkg::VAL_W-1:0] list_mem [DEPTH];
    int                        list_count = 0;
    logic [sle_pkg::CAP_W-1:0] cap_reg = sle_pkg::CAP_RESET;

    t_request         request_q [$];
    sle_pkg::t_result predicted_results [$];

    int in_acc_cnt = 0;
    int in_sent_cnt = 0;
    int result_cnt = 0;
    int err_cnt = 0;
    int op_seen [8];
    int peak_count = 0;
    int locate_hits = 0;
    int full_rejects = 0;

    // generator-side view of the list size
    int gen_cnt = 0;
    int gen_cap = DEPTH;

    function automatic int eff_cap(input logic [sle_pkg::CAP_W-1:0] c);
        if (c == 0) return 1;
        if (c > DEPTH) return DEPTH;
        return int'(c);
    endfunction

    task automatic apply_list_op(input t_request rq, output sle_pkg::t_result r);
        int capn;
        int i;
        capn = eff_cap(cap_reg);
        r = '0;
        r.status = sle_pkg::ST_OK;
        case (rq.op)
            sle_pkg::OP_INSERT: begin
                if (rq.pos < 1 || rq.pos > list_count + 1 || list_count >= capn) begin
                    r.status = sle_pkg::ST_BAD;
                    if (list_count >= capn) full_rejects++;
                end else begin
                    for (i = list_count; i > rq.pos - 1; i--) list_mem[i] = list_mem[i-1];
                    list_mem[rq.pos-1] = rq.val;
                    list_count++;
                end
            end
            sle_pkg::OP_DELETE: begin
                if (list_count == 0 || rq.pos < 1 || rq.pos > list_count) begin
                    r.status = sle_pkg::ST_BAD;
                end else begin
                    r.read_value = list_mem[rq.pos-1];
                    for (i = rq.pos - 1; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            end
            sle_pkg::OP_GET: begin
                if (rq.pos < 1 || rq.pos > list_count) r.status = sle_pkg::ST_BAD;
                else r.read_value = list_mem[rq.pos-1];
            end
            sle_pkg::OP_LOCATE: begin
                r.status = sle_pkg::ST_NOTFOUND;
                for (i = 0; i < list_count; i++) begin
                    if (list_mem[i] == rq.val) begin
                        r.found_position = sle_pkg::POS_W'(i + 1);
                        r.status = sle_pkg::ST_OK;
                        locate_hits++;
                        break;
                    end
                end
            end
            sle_pkg::OP_CLEAR: list_count = 0;
            default: r.status = sle_pkg::ST_BAD;
        endcase
        r.element_count = sle_pkg::CNT_W'(list_count);
        r.is_empty = (list_count == 0);
        r.is_full = (list_count >= capn);
        if (list_count > peak_count) peak_count = list_count;
    endtask

    task automatic note_error(input string what, input sle_pkg::t_result want,
                              input sle_pkg::t_result got);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t error: %s exp st=%0d rd=%0h fp=%0d cnt=%0d e=%0b f=%0b",
                     $time, what, want.status, want.read_value, want.found_position,
                     want.element_count, want.is_empty, want.is_full);
            $display("      got st=%0d rd=%0h fp=%0d cnt=%0d e=%0b f=%0b",
                     got.status, got.read_value, got.found_position,
                     got.element_count, got.is_empty, got.is_full);
        end
    endtask

    // prediction and checking
    always @(posedge i_clk) begin
        sle_pkg::t_result got;
        sle_pkg::t_result want;
        if (!i_rst_n) begin
            list_count = 0;
            cap_reg = sle_pkg::CAP_RESET;
        end else begin
            if (i_cfg_we) cap_reg = i_cfg_wdata;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_list_op(t_request'({i_s_axis_tdata[2:0], i_s_axis_tdata[9:3],
                                          i_s_axis_tdata[17:10]}), want);
                op_seen[i_s_axis_tdata[2:0]]++;
                predicted_results.push_back(want);
                in_acc_cnt <= in_acc_cnt + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.status         = o_m_axis_tdata[1:0];
                got.read_value     = o_m_axis_tdata[9:2];
                got.found_position = o_m_axis_tdata[16:10];
                got.element_count  = o_m_axis_tdata[23:17];
                got.is_empty       = o_m_axis_tdata[24];
                got.is_full        = o_m_axis_tdata[25];
                result_cnt++;
                if (predicted_results.size() == 0) begin
                    note_error("unexpected result", '0, got);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value ||
                        got.found_position !== want.found_position ||
                        got.element_count !== want.element_count ||
                        got.is_empty !== want.is_empty || got.is_full !== want.is_full)
                        note_error("result mismatch", want, got);
                end
            end
        end
    end

    // sender: bursts with gaps
    int burst_left = 8;
    int gap_left = 0;

    always @(negedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && in_acc_cnt != in_sent_cnt) begin
            // hold the offered item
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
            nxt = request_q.pop_front();
            i_s_axis_tdata <= {6'd0, nxt.val, nxt.pos, nxt.op};
            i_s_axis_tvalid <= 1'b1;
            in_sent_cnt = in_sent_cnt + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern plus one long hold-off
    int  rx_cyc = 0;
    int  rx_hold = 0;
    bit  held_once = 1'b0;

    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!held_once && in_acc_cnt >= 150) begin
            held_once <= 1'b1;
            rx_hold <= 300;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_cyc[9:7])
                3'd0, 3'd1: i_m_axis_tready <= 1'b1;
                3'd2:       i_m_axis_tready <= ($urandom_range(0, 1) == 0);
                3'd3:       i_m_axis_tready <= (rx_cyc[1:0] == 2'd0);
                3'd4:       i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:    i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic add_item(input logic [sle_pkg::OP_W-1:0] op, input int pos, input int val);
        t_request rq;
        rq.op = op;
        rq.pos = sle_pkg::POS_W'(pos);
        rq.val = sle_pkg::VAL_W'(val);
        request_q.push_back(rq);
        case (op)
            sle_pkg::OP_INSERT:
                if (pos >= 1 && pos <= gen_cnt + 1 && gen_cnt < gen_cap) gen_cnt++;
            sle_pkg::OP_DELETE: if (pos >= 1 && pos <= gen_cnt) gen_cnt--;
            sle_pkg::OP_CLEAR:  gen_cnt = 0;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || in_acc_cnt != in_sent_cnt ||
               predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        gen_cnt = list_count;
    endtask

    task automatic set_capacity(input logic [sle_pkg::CAP_W-1:0] c);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= c;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_cap = eff_cap(c);
    endtask

    function automatic int pick_value();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    endfunction

    task automatic gen_random(input int n);
        int k;
        int sel;
        int pos;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 12) pos = $urandom_range(0, 127);
            else if (sel < 45) pos = ($urandom_range(0, 3) == 0) ? 1 :
                                     ($urandom_range(0, 2) == 0) ? gen_cnt + 1 :
                                     $urandom_range(1, gen_cnt + 1);
            else pos = (gen_cnt == 0) ? $urandom_range(0, 3) : $urandom_range(1, gen_cnt);
            if (sel < 45)      add_item(sle_pkg::OP_INSERT, pos, pick_value());
            else if (sel < 65) add_item(sle_pkg::OP_DELETE, pos, $urandom_range(0, 255));
            else if (sel < 80) add_item(sle_pkg::OP_GET, pos, $urandom_range(0, 255));
            else if (sel < 95) add_item(sle_pkg::OP_LOCATE, pos, pick_value());
            else if (sel < 97) add_item(sle_pkg::OP_CLEAR, pos, $urandom_range(0, 255));
            else add_item(sle_pkg::OP_CLEAR + sle_pkg::OP_W'($urandom_range(1, 3)), pos,
                          $urandom_range(0, 255));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, list ends, bad positions, unused codes
        add_item(sle_pkg::OP_GET, 1, 0);
        add_item(sle_pkg::OP_DELETE, 1, 0);
        add_item(sle_pkg::OP_LOCATE, 0, 0);
        add_item(sle_pkg::OP_INSERT, 0, 8'h11);
        add_item(sle_pkg::OP_INSERT, 2, 8'h22);
        add_item(sle_pkg::OP_INSERT, 1, 8'h00);
        add_item(sle_pkg::OP_INSERT, 2, 8'hFF);
        add_item(sle_pkg::OP_INSERT, 1, 8'h80);
        add_item(sle_pkg::OP_INSERT, 2, 8'h7F);
        add_item(sle_pkg::OP_INSERT, 127, 8'h33);
        add_item(sle_pkg::OP_GET, 0, 0);
        add_item(sle_pkg::OP_GET, 4, 0);
        add_item(sle_pkg::OP_GET, 5, 0);
        add_item(sle_pkg::OP_LOCATE, 0, 8'hFF);
        add_item(sle_pkg::OP_LOCATE, 0, 8'h55);
        add_item(sle_pkg::OP_DELETE, 5, 0);
        add_item(sle_pkg::OP_DELETE, 4, 0);
        add_item(sle_pkg::OP_DELETE, 1, 0);
        add_item(sle_pkg::OP_CLEAR + sle_pkg::OP_W'(1), 1, 8'h01);
        add_item(sle_pkg::OP_CLEAR + sle_pkg::OP_W'(2), 1, 8'h02);
        add_item(sle_pkg::OP_CLEAR + sle_pkg::OP_W'(3), 127, 8'hFF);
        add_item(sle_pkg::OP_CLEAR, 0, 0);
        add_item(sle_pkg::OP_DELETE, 0, 0);

        // capacity zero acts as one
        set_capacity(7'd0);
        add_item(sle_pkg::OP_INSERT, 1, 8'hA5);
        add_item(sle_pkg::OP_INSERT, 1, 8'h5A);
        add_item(sle_pkg::OP_GET, 1, 0);

        // capacity lowered below the count
        set_capacity(7'd64);
        add_item(sle_pkg::OP_INSERT, 1, 8'h01);
        add_item(sle_pkg::OP_INSERT, 1, 8'h02);
        add_item(sle_pkg::OP_INSERT, 1, 8'h03);
        set_capacity(7'd2);
        add_item(sle_pkg::OP_INSERT, 1, 8'h04);
        add_item(sle_pkg::OP_DELETE, 1, 0);
        add_item(sle_pkg::OP_DELETE, 1, 0);
        add_item(sle_pkg::OP_INSERT, 3, 8'h05);

        set_capacity(7'd127);
        gen_random(80);
        set_capacity(7'd1);
        gen_random(30);
        set_capacity(7'd2);
        gen_random(30);
        set_capacity(7'd64);
        gen_random(90);
        set_capacity(7'($urandom_range(3, 63)));
        gen_random(50);
        set_capacity(7'd5);
        gen_random(40);
        set_capacity(7'd100);
        gen_random(50);
        set_capacity(7'd0);
        gen_random(20);
        set_capacity(7'd64);
        gen_random(30);

        wait_idle();
        if (predicted_results.size() != 0) err_cnt++;

        $display("run: %0d items, %0d results; ins %0d del %0d get %0d loc %0d clr %0d bad %0d",
                 in_acc_cnt, result_cnt, op_seen[sle_pkg::OP_INSERT],
                 op_seen[sle_pkg::OP_DELETE], op_seen[sle_pkg::OP_GET],
                 op_seen[sle_pkg::OP_LOCATE], op_seen[sle_pkg::OP_CLEAR],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("list peaked at %0d entries, %0d locate hits, %0d inserts refused when full",
                 peak_count, locate_hits, full_rejects);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors", err_cnt);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
src/sle_pkg.sv
src/sle_mem.sv
src/sle_ctrl.sv
src/sequential_list_engine.sv
verif/sequential_list_engine_test.sv
